// ===== rtl/core/knn_weighted_pixel_fill_macros.svh =====
// assertion helpers used by the bound checker knnwpf_chk
`ifndef KNN_WEIGHTED_PIXEL_FILL_MACROS_SVH
`define KNN_WEIGHTED_PIXEL_FILL_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define KNNWPF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define KNNWPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/knnwpf_pkg.sv =====
`timescale 1ns / 1ps
package knnwpf_pkg;

	// default sizes
	localparam int SAMPLE_CAP_DEF = 4096;
	localparam int MAX_K_DEF      = 16;
	localparam int COORD_BITS_DEF = 10;

	// fixed field widths
	localparam int COL_W      = 8;
	localparam int ACT_W      = 2;
	localparam int NF_W       = 5;
	localparam int K_W        = 5;
	localparam int P_W        = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [K_W-1:0] K_RESET = 5'd4;
	localparam logic [P_W-1:0] P_RESET = 2'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_K_NEIGHBORS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_POWER = 1'd1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clear;
		logic query;
		logic scan;
		logic root;
		logic weigh;
		logic divide;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic root_done;
		logic weigh_done;
		logic div_done;
		logic interp;
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/core/knnwpf_if.sv =====
`timescale 1ns / 1ps
// request channel: load, query or clear
interface knnwpf_req_if #(
	parameter int COORD_BITS = knnwpf_pkg::COORD_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [knnwpf_pkg::ACT_W-1:0]      action;
	logic [COORD_BITS-1:0]             pos_x;
	logic [COORD_BITS-1:0]             pos_y;
	logic [knnwpf_pkg::COL_W-1:0]      in_red;
	logic [knnwpf_pkg::COL_W-1:0]      in_green;
	logic [knnwpf_pkg::COL_W-1:0]      in_blue;

	modport source (output valid, action, pos_x, pos_y, in_red, in_green, in_blue,
		input ready);
	modport sink (input valid, action, pos_x, pos_y, in_red, in_green, in_blue,
		output ready);
endinterface

// response channel: one filled pixel per query
interface knnwpf_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [knnwpf_pkg::COL_W-1:0]      out_red;
	logic [knnwpf_pkg::COL_W-1:0]      out_green;
	logic [knnwpf_pkg::COL_W-1:0]      out_blue;
	logic [knnwpf_pkg::NF_W-1:0]       neighbors_found;
	logic                              store_empty;

	modport source (output valid, out_red, out_green, out_blue, neighbors_found,
		store_empty, input ready);
	modport sink (input valid, out_red, out_green, out_blue, neighbors_found,
		store_empty, output ready);
endinterface

// ===== rtl/core/knn_weighted_pixel_fill.sv =====
// load and clear: accepted whenever the block is idle
// query: a scan over the N stored samples (one store read a cycle), then, when neighbours
//   were found and K > 1, a square-root pass and a weight pass over the F neighbours
//   and a divider pass over the three colour channels
// a finished result waits in the output register while the next item is taken
// reset: control cleared, store count zero, K = 4, power = 1; the store itself is not swept
`timescale 1ns / 1ps
module knn_weighted_pixel_fill #(
	parameter int SAMPLE_CAP = knnwpf_pkg::SAMPLE_CAP_DEF,
	parameter int MAX_K      = knnwpf_pkg::MAX_K_DEF,
	parameter int COORD_BITS = knnwpf_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	knnwpf_req_if.sink                        req,
	knnwpf_rsp_if.source                      rsp,
	input  logic                              wr_en,
	input  logic [knnwpf_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [knnwpf_pkg::CFG_DATA_W-1:0] wr_data
);

	knnwpf_pkg::cmd_t  cmd;
	knnwpf_pkg::stat_t stat;

	// sequencer
	knnwpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.action    (req.action),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// store, search and interpolation
	knnwpf_dp #(
		.SAMPLE_CAP (SAMPLE_CAP),
		.MAX_K      (MAX_K),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_idx          (wr_idx),
		.wr_data         (wr_data),
		.pos_x           (req.pos_x),
		.pos_y           (req.pos_y),
		.in_red          (req.in_red),
		.in_green        (req.in_green),
		.in_blue         (req.in_blue),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_red         (rsp.out_red),
		.out_green       (rsp.out_green),
		.out_blue        (rsp.out_blue),
		.neighbors_found (rsp.neighbors_found),
		.store_empty     (rsp.store_empty)
	);

endmodule

// ===== rtl/core/knnwpf_ram.sv =====
`timescale 1ns / 1ps
module knnwpf_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/knnwpf_ctrl.sv =====
`timescale 1ns / 1ps
module knnwpf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic [knnwpf_pkg::ACT_W-1:0] action,
	output logic                         req_ready,
	output knnwpf_pkg::cmd_t             cmd,
	input  knnwpf_pkg::stat_t            stat
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_ROOT   = 6'b000100,
		ST_WEIGH  = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   take;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_ready && req_valid;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load  = take && (action == knnwpf_pkg::ACT_LOAD);
				cmd.clear = take && (action == knnwpf_pkg::ACT_CLEAR);
				cmd.query = take && (action == knnwpf_pkg::ACT_QUERY);
				if (cmd.query) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = stat.interp ? ST_ROOT : ST_DONE;
				end
			end
			ST_ROOT: begin
				cmd.root = 1'b1;
				if (stat.root_done) begin
					state_nxt = ST_WEIGH;
				end
			end
			ST_WEIGH: begin
				cmd.weigh = 1'b1;
				if (stat.weigh_done) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				if (stat.div_done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/core/knnwpf_dp.sv =====
`timescale 1ns / 1ps
module knnwpf_dp #(
	parameter int SAMPLE_CAP = knnwpf_pkg::SAMPLE_CAP_DEF,
	parameter int MAX_K      = knnwpf_pkg::MAX_K_DEF,
	parameter int COORD_BITS = knnwpf_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              wr_en,
	input  logic [knnwpf_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [knnwpf_pkg::CFG_DATA_W-1:0] wr_data,
	// request payload
	input  logic [COORD_BITS-1:0]             pos_x,
	input  logic [COORD_BITS-1:0]             pos_y,
	input  logic [knnwpf_pkg::COL_W-1:0]      in_red,
	input  logic [knnwpf_pkg::COL_W-1:0]      in_green,
	input  logic [knnwpf_pkg::COL_W-1:0]      in_blue,
	// control
	input  knnwpf_pkg::cmd_t                  cmd,
	output knnwpf_pkg::stat_t                 stat,
	// response
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [knnwpf_pkg::COL_W-1:0]      out_red,
	output logic [knnwpf_pkg::COL_W-1:0]      out_green,
	output logic [knnwpf_pkg::COL_W-1:0]      out_blue,
	output logic [knnwpf_pkg::NF_W-1:0]       neighbors_found,
	output logic                              store_empty
);

	localparam int CW     = knnwpf_pkg::COL_W;
	localparam int CNT_W  = $clog2(SAMPLE_CAP + 1);
	localparam int AW     = $clog2(SAMPLE_CAP);
	localparam int ENT_W  = 2 * COORD_BITS + 3 * CW;
	localparam int KB     = $clog2(MAX_K + 1);
	localparam int LI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int DSQ_W  = 2 * COORD_BITS + 1;
	localparam int KEY_W  = DSQ_W + 3 * CW;
	localparam int RW     = COORD_BITS + 5;
	localparam int VE     = 2 * RW;
	localparam int RS_W   = $clog2(RW);
	localparam int S_W    = COORD_BITS + 1 + KB;
	localparam int MAG_W  = S_W + 4;
	localparam int W_W    = S_W + 5;
	localparam int TERM_W = 3 * MAG_W;
	localparam int ST_W   = TERM_W + 1;
	localparam int PR_W   = ST_W + CW + 1;
	localparam int TOT_W  = ST_W + KB;
	localparam int NUM_W  = PR_W + KB;
	localparam int DV_W   = NUM_W + CW;
	localparam int WS_W   = 3;

	// configuration registers
	logic [knnwpf_pkg::K_W-1:0] k_neighbors_q;
	logic [knnwpf_pkg::P_W-1:0] weight_power_q;
	logic [KB-1:0]              k_eff;

	// sample store
	logic [CNT_W-1:0] count_q;
	logic             ram_we;
	logic [ENT_W-1:0] ram_rdata;
	logic [CNT_W-1:0] rd_idx_q;
	logic             issue;

	// scan pipeline
	logic [COORD_BITS-1:0]           qx_q, qy_q;
	logic                            v_s1, v_s2;
	logic signed [COORD_BITS:0]      dx, dy;
	logic signed [2*COORD_BITS+1:0]  sqx, sqy;
	logic [KEY_W-1:0]                key_s2;

	// ranked neighbour lanes
	logic [KEY_W-1:0] key_q [MAX_K];
	logic [KEY_W-1:0] ins_key [MAX_K];
	logic [MAX_K-1:0] lt;
	logic [KB-1:0]    found_q;
	logic             scan_ins;

	// shared lane counter for root and weight passes
	logic [LI_W-1:0]  lane_q;
	logic             lane_last;
	logic [KEY_W-1:0] lane_key;

	// integer square root
	logic [RS_W-1:0]  rstep_q;
	logic [VE-1:0]    rval_q, cur_val;
	logic [RW+1:0]    rrem_q, cur_rem, new_rem;
	logic [RW-1:0]    rroot_q, cur_root, new_root;
	logic [RW+3:0]    remx, trial;
	logic             rge, root_last;
	logic [RW-1:0]    dist_q [MAX_K];
	logic [S_W-1:0]   s_q;

	// weight terms and sums
	logic [WS_W-1:0]           wstep_q, wmul_end;
	logic signed [W_W-1:0]     wv;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [TERM_W-1:0]         term_q;
	logic signed [ST_W-1:0]    st_val, st_q;
	logic signed [PR_W-1:0]    pr_q [3];
	logic signed [TOT_W-1:0]   tot_q;
	logic signed [NUM_W-1:0]   num_q [3];
	logic [CW-1:0]             lane_col [3];
	logic                      wlast;

	// divider
	logic [1:0]                ch_q;
	logic [3:0]                dstep_q;
	logic [NUM_W-1:0]          rem_q, den_q, rem_nxt, num_mag, tot_mag;
	logic signed [NUM_W-1:0]   num_sel;
	logic                      dzero_q, fits;
	logic [2:0]                bitpos;
	logic [DV_W-1:0]           den_sh;
	logic [CW-1:0]             q_q, q_nxt;
	logic [CW-1:0]             res_q [3];

	// output register
	logic                      out_valid_q;
	logic [CW-1:0]             o_col_q [3];
	logic [knnwpf_pkg::NF_W-1:0] o_nf_q;
	logic                      o_empty_q;
	logic                      interp, use_div;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_neighbors_q  <= knnwpf_pkg::K_RESET;
			weight_power_q <= knnwpf_pkg::P_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				knnwpf_pkg::CFG_K_NEIGHBORS:  k_neighbors_q  <= wr_data;
				knnwpf_pkg::CFG_WEIGHT_POWER: weight_power_q <= wr_data[knnwpf_pkg::P_W-1:0];
				default: ;
			endcase
		end
	end

	// k clamped to 1..MAX_K
	always_comb begin
		if (k_neighbors_q == '0) begin
			k_eff = KB'(1);
		end else if (int'(k_neighbors_q) > MAX_K) begin
			k_eff = KB'(MAX_K);
		end else begin
			k_eff = KB'(k_neighbors_q);
		end
	end

	// sample store and fill count
	assign ram_we = cmd.load && (int'(count_q) < SAMPLE_CAP);
	assign issue  = cmd.scan && (rd_idx_q < count_q);

	knnwpf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SAMPLE_CAP)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({pos_x, pos_y, in_red, in_green, in_blue}),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// scan: read address, then squared distance, then ranked insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cmd.query) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
		end
	end

	assign dx  = $signed({1'b0, ram_rdata[ENT_W-1 -: COORD_BITS]}) - $signed({1'b0, qx_q});
	assign dy  = $signed({1'b0, ram_rdata[ENT_W-COORD_BITS-1 -: COORD_BITS]})
		- $signed({1'b0, qy_q});
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	always_ff @(posedge clk) begin
		key_s2 <= {DSQ_W'(sqx) + DSQ_W'(sqy), ram_rdata[3*CW-1:0]};
	end

	assign scan_ins = cmd.scan && v_s2;

	// each lane takes the new key or its upper neighbour
	genvar g;
	generate
		for (g = 0; g < MAX_K; g++) begin : g_lane
			assign lt[g] = (KB'(g) >= found_q) || (key_s2 < key_q[g]);
			if (g == 0) begin : g_first
				assign ins_key[g] = key_s2;
			end else begin : g_rest
				assign ins_key[g] = lt[g-1] ? key_q[g-1] : key_s2;
			end
			always_ff @(posedge clk) begin
				if (scan_ins && lt[g]) begin
					key_q[g] <= ins_key[g];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (cmd.query) begin
			found_q <= '0;
		end else if (scan_ins && (found_q < k_eff)) begin
			found_q <= found_q + KB'(1);
		end
	end

	assign interp = (found_q != '0) && (k_eff > KB'(1));

	// lane selection shared by root and weight passes
	assign lane_key  = key_q[lane_q];
	assign lane_last = (KB'(lane_q) == (found_q - KB'(1)));

	// square root of the squared distance times 256, two radicand bits per cycle
	always_comb begin
		cur_val  = (rstep_q == '0) ? {{(VE-DSQ_W-8){1'b0}}, lane_key[KEY_W-1 -: DSQ_W], 8'b0}
			: rval_q;
		cur_rem  = (rstep_q == '0) ? '0 : rrem_q;
		cur_root = (rstep_q == '0) ? '0 : rroot_q;
		remx     = {cur_rem, cur_val[VE-1 -: 2]};
		trial    = (RW+4)'({cur_root, 2'b01});
		rge      = (remx >= trial);
		new_rem  = (RW+2)'(rge ? (remx - trial) : remx);
		new_root = {cur_root[RW-2:0], rge};
	end

	assign root_last = (rstep_q == RS_W'(RW - 1));

	// weight step sequence: term, P multiplies, sign and colour products, accumulate
	assign wmul_end = WS_W'(weight_power_q);
	assign wlast    = (wstep_q == (wmul_end + WS_W'(2)));
	assign wv       = $signed(W_W'({s_q, 4'b0})) - $signed(W_W'(dist_q[lane_q]));
	assign st_val   = (neg_q && weight_power_q[0]) ? -$signed({1'b0, term_q})
		: $signed({1'b0, term_q});
	assign lane_col[0] = lane_key[3*CW-1 -: CW];
	assign lane_col[1] = lane_key[2*CW-1 -: CW];
	assign lane_col[2] = lane_key[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q  <= '0;
			rstep_q <= '0;
			wstep_q <= '0;
		end else if (cmd.query) begin
			lane_q  <= '0;
			rstep_q <= '0;
			wstep_q <= '0;
		end else if (cmd.root) begin
			rstep_q <= root_last ? '0 : rstep_q + RS_W'(1);
			if (root_last) begin
				lane_q <= lane_last ? '0 : lane_q + LI_W'(1);
			end
		end else if (cmd.weigh) begin
			wstep_q <= wlast ? '0 : wstep_q + WS_W'(1);
			if (wlast) begin
				lane_q <= lane_q + LI_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			s_q <= '0;
		end else if (cmd.root) begin
			rval_q  <= cur_val << 2;
			rrem_q  <= new_rem;
			rroot_q <= new_root;
			if (root_last) begin
				dist_q[lane_q] <= new_root;
				s_q            <= s_q + S_W'(new_root >> 4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			tot_q <= '0;
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= '0;
			end
		end else if (cmd.weigh) begin
			if (wstep_q == '0) begin
				neg_q  <= wv[W_W-1];
				mag_q  <= MAG_W'(wv[W_W-1] ? -wv : wv);
				term_q <= TERM_W'(1);
			end else if (wstep_q <= wmul_end) begin
				term_q <= TERM_W'(term_q[2*MAG_W-1:0] * mag_q);
			end else if (!wlast) begin
				st_q <= st_val;
				for (int c = 0; c < 3; c++) begin
					pr_q[c] <= st_val * $signed({1'b0, lane_col[c]});
				end
			end else begin
				tot_q <= tot_q + TOT_W'(st_q);
				for (int c = 0; c < 3; c++) begin
					num_q[c] <= num_q[c] + NUM_W'(pr_q[c]);
				end
			end
		end
	end

	// restoring divider, one quotient bit a cycle, channels in turn
	assign num_sel = num_q[ch_q];
	assign num_mag = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
	assign tot_mag = tot_q[TOT_W-1] ? NUM_W'(-tot_q) : NUM_W'(tot_q);
	assign bitpos  = 3'(4'd8 - dstep_q);
	assign den_sh  = DV_W'(den_q) << bitpos;
	assign fits    = (den_sh <= DV_W'(rem_q));
	assign rem_nxt = fits ? NUM_W'(DV_W'(rem_q) - den_sh) : rem_q;
	assign q_nxt   = q_q | (fits ? (CW'(1) << bitpos) : CW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			dstep_q <= '0;
		end else if (cmd.query) begin
			ch_q    <= '0;
			dstep_q <= '0;
		end else if (cmd.divide) begin
			if (dstep_q == 4'd8) begin
				dstep_q <= '0;
				ch_q    <= ch_q + 2'd1;
			end else begin
				dstep_q <= dstep_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.divide) begin
			if (dstep_q == '0) begin
				rem_q   <= num_mag;
				den_q   <= tot_mag;
				dzero_q <= (num_sel[NUM_W-1] != tot_q[TOT_W-1]);
				q_q     <= '0;
			end else begin
				rem_q <= rem_nxt;
				q_q   <= q_nxt;
				if (dstep_q == 4'd8) begin
					res_q[ch_q] <= dzero_q ? '0 : q_nxt;
				end
			end
		end
	end

	// output register
	assign use_div = interp && (tot_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			o_nf_q    <= knnwpf_pkg::NF_W'(found_q);
			o_empty_q <= (found_q == '0);
			for (int c = 0; c < 3; c++) begin
				if (found_q == '0) begin
					o_col_q[c] <= '0;
				end else if (use_div) begin
					o_col_q[c] <= res_q[c];
				end else begin
					o_col_q[c] <= key_q[0][(3-c)*CW-1 -: CW];
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_red         = o_col_q[0];
	assign out_green       = o_col_q[1];
	assign out_blue        = o_col_q[2];
	assign neighbors_found = o_nf_q;
	assign store_empty     = o_empty_q;

	// status back to the controller
	assign stat.scan_done  = cmd.scan && !issue && !v_s1 && !v_s2;
	assign stat.root_done  = cmd.root && root_last && lane_last;
	assign stat.weigh_done = cmd.weigh && wlast && lane_last;
	assign stat.div_done   = cmd.divide && (dstep_q == 4'd8) && (ch_q == 2'd2);
	assign stat.interp     = interp;
	assign stat.out_busy   = out_valid_q;

endmodule

// ===== rtl/core/knnwpf_chk.sv =====
`timescale 1ns / 1ps
`include "knn_weighted_pixel_fill_macros.svh"
module knnwpf_chk #(
	parameter int MAX_K = knnwpf_pkg::MAX_K_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [knnwpf_pkg::COL_W-1:0]    out_red,
	input logic [knnwpf_pkg::COL_W-1:0]    out_green,
	input logic [knnwpf_pkg::COL_W-1:0]    out_blue,
	input logic [knnwpf_pkg::NF_W-1:0]     neighbors_found,
	input logic                            store_empty
);

	// a stalled result stays offered
	`KNNWPF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	// empty store gives black and no neighbours
	`KNNWPF_ASSERT(a_empty_black, rsp_valid && store_empty, (neighbors_found == '0) && (out_red == '0) && (out_green == '0) && (out_blue == '0), "empty store result not zero")

	// a non-empty result used at least one neighbour
	`KNNWPF_ASSERT(a_found_nonzero, rsp_valid && !store_empty, neighbors_found != '0, "no neighbours on a filled store")

	// never more neighbours than the lanes hold
	`KNNWPF_ASSERT(a_found_bound, rsp_valid, int'(neighbors_found) <= MAX_K, "neighbour count above lane count")

endmodule

bind knn_weighted_pixel_fill knnwpf_chk #(
	.MAX_K (MAX_K)
) u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.out_red         (rsp.out_red),
	.out_green       (rsp.out_green),
	.out_blue        (rsp.out_blue),
	.neighbors_found (rsp.neighbors_found),
	.store_empty     (rsp.store_empty)
);

// ===== dv/knn_weighted_pixel_fill_checker.sv =====
`timescale 1ns / 1ps
module knn_weighted_pixel_fill_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	knnwpf_req_if                             req,
	knnwpf_rsp_if                             rsp,
	input  logic                              wr_en,
	input  logic [knnwpf_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [knnwpf_pkg::CFG_DATA_W-1:0] wr_data,
	output int                                fail_count,
	output int                                pending
);

	localparam int CAP = knnwpf_pkg::SAMPLE_CAP_DEF;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} sample_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [4:0] found;
		logic       empty;
	} pixel_t;

	sample_t     store [CAP];
	int          count;
	logic [4:0]  k_reg;
	logic [1:0]  p_reg;
	pixel_t      pred_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q, fill;

	// predictions waiting for their response transaction
	assign fill    = wr_ptr_q - rd_ptr_q;
	assign pending = int'(fill);

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// colour order used to break distance ties
	function automatic bit colour_before(sample_t a, sample_t b);
		if (a.r != b.r) return a.r < b.r;
		if (a.g != b.g) return a.g < b.g;
		return a.b < b.b;
	endfunction

	function automatic logic [7:0] sat_quot(logic signed [127:0] num, logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		if (q < 0) return 8'd0;
		if (q > 255) return 8'd255;
		return q[7:0];
	endfunction

	// k nearest search and distance weighted blend
	function automatic pixel_t fill_pixel(logic [9:0] px, logic [9:0] py);
		pixel_t              res;
		int                  k, found, pos;
		int                  idx [16];
		longint unsigned     dsq [16];
		longint unsigned     dd, d [16], s;
		longint signed       w;
		logic signed [127:0] term, tot, nr, ng, nb;
		sample_t             c;
		res = '0;
		k = (k_reg < 1) ? 1 : (k_reg > 16 ? 16 : k_reg);
		found = 0;
		for (int i = 0; i < count; i++) begin
			dd = longint'(int'(store[i].x) - int'(px)) ** 2
				+ longint'(int'(store[i].y) - int'(py)) ** 2;
			pos = found;
			while (pos > 0 && (dd < dsq[pos-1] || (dd == dsq[pos-1]
				&& colour_before(store[i], store[idx[pos-1]]))))
				pos--;
			if (pos >= k) continue;
			if (found < k) found++;
			for (int j = found - 1; j > pos; j--) begin
				idx[j] = idx[j-1];
				dsq[j] = dsq[j-1];
			end
			idx[pos] = i;
			dsq[pos] = dd;
		end
		res.found = found[4:0];
		res.empty = (found == 0);
		if (found == 0) return res;
		c = store[idx[0]];
		res.red = c.r;
		res.green = c.g;
		res.blue = c.b;
		if (k == 1) return res;
		s = 0;
		for (int j = 0; j < found; j++) begin
			d[j] = int_sqrt(dsq[j] << 8);
			s += d[j] >> 4;
		end
		tot = 0; nr = 0; ng = 0; nb = 0;
		for (int j = 0; j < found; j++) begin
			w = longint'(s << 4) - longint'(d[j]);
			term = 1;
			for (int i = 0; i < p_reg; i++) term = term * w;
			c = store[idx[j]];
			tot += term;
			nr += term * c.r;
			ng += term * c.g;
			nb += term * c.b;
		end
		if (tot != 0) begin
			res.red = sat_quot(nr, tot);
			res.green = sat_quot(ng, tot);
			res.blue = sat_quot(nb, tot);
		end
		return res;
	endfunction

	// model update on each request transaction and register write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count    <= 0;
			k_reg    <= knnwpf_pkg::K_RESET;
			p_reg    <= knnwpf_pkg::P_RESET;
			wr_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				if (wr_idx == knnwpf_pkg::CFG_K_NEIGHBORS) k_reg <= wr_data;
				else if (wr_idx == knnwpf_pkg::CFG_WEIGHT_POWER) p_reg <= wr_data[1:0];
			end
			if (req.valid && req.ready) begin
				case (req.action)
					knnwpf_pkg::ACT_LOAD: begin
						if (count < CAP) begin
							store[count] <= '{req.pos_x, req.pos_y, req.in_red,
								req.in_green, req.in_blue};
							count <= count + 1;
						end
					end
					knnwpf_pkg::ACT_CLEAR: count <= 0;
					knnwpf_pkg::ACT_QUERY: begin
						pred_q[wr_ptr_q] <= fill_pixel(req.pos_x, req.pos_y);
						wr_ptr_q         <= wr_ptr_q + 2'd1;
					end
					default: ;
				endcase
			end
		end
	end

	// compare each response transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		if (!arst_n) begin
			fail_count <= 0;
			rd_ptr_q   <= '0;
		end else if (rsp.valid && rsp.ready) begin
			if (wr_ptr_q == rd_ptr_q) begin
				$error("unexpected response transaction");
				fail_count <= fail_count + 1;
			end else begin
				e = pred_q[rd_ptr_q];
				rd_ptr_q <= rd_ptr_q + 2'd1;
				if (e.red !== rsp.out_red || e.green !== rsp.out_green
					|| e.blue !== rsp.out_blue || e.found !== rsp.neighbors_found
					|| e.empty !== rsp.store_empty) begin
					fail_count <= fail_count + 1;
					if (e.red !== rsp.out_red)
						$error("out_red expected %0d got %0d", e.red, rsp.out_red);
					if (e.green !== rsp.out_green)
						$error("out_green expected %0d got %0d", e.green, rsp.out_green);
					if (e.blue !== rsp.out_blue)
						$error("out_blue expected %0d got %0d", e.blue, rsp.out_blue);
					if (e.found !== rsp.neighbors_found)
						$error("neighbors_found expected %0d got %0d", e.found,
							rsp.neighbors_found);
					if (e.empty !== rsp.store_empty)
						$error("store_empty expected %0d got %0d", e.empty,
							rsp.store_empty);
				end
			end
		end
	end
endmodule

// ===== dv/knn_weighted_pixel_fill_tb.sv =====
`timescale 1ns / 1ps
module knn_weighted_pixel_fill_tb;

	// action code that the block ignores
	localparam logic [knnwpf_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

	logic                              clk = 0;
	logic                              arst_n = 0;
	logic                              wr_en = 0;
	logic [knnwpf_pkg::CFG_IDX_W-1:0]  wr_idx = '0;
	logic [knnwpf_pkg::CFG_DATA_W-1:0] wr_data = '0;
	int                                fail_count, pending;
	int                                send_idle, recv_stall;
	longint                            cycles = 0;

	knnwpf_req_if req ();
	knnwpf_rsp_if rsp ();

	knn_weighted_pixel_fill DUT (.clk, .arst_n, .req, .rsp, .wr_en, .wr_idx, .wr_data);

	knn_weighted_pixel_fill_checker chk (.clk, .arst_n, .req, .rsp, .wr_en, .wr_idx,
		.wr_data, .fail_count, .pending);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver with random stalls
	always @(posedge clk) rsp.ready <= ($urandom_range(99) >= recv_stall);

	// one request transaction, with random idle cycles before it; valid stays up after it
	task automatic send(logic [knnwpf_pkg::ACT_W-1:0] a, logic [9:0] x, logic [9:0] y,
		logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1; req.action <= a; req.pos_x <= x; req.pos_y <= y;
		req.in_red <= r; req.in_green <= g; req.in_blue <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic send_rand(logic [knnwpf_pkg::ACT_W-1:0] a);
		send(a, 10'($urandom), 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// drain, settle, then write a register
	task automatic write_reg(logic [knnwpf_pkg::CFG_IDX_W-1:0] i,
		logic [knnwpf_pkg::CFG_DATA_W-1:0] v);
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		wr_en <= 1; wr_idx <= i; wr_data <= v;
		@(posedge clk);
		wr_en <= 0;
	endtask

	// a random phase: loads and queries mixed with some clears and ignored actions, mostly well formed
	task automatic phase(int items);
		for (int n = 0; n < items; n++) begin
			case ($urandom_range(19))
				0: send_rand(knnwpf_pkg::ACT_CLEAR);
				1: send_rand(ACT_NONE);
				2, 3, 4, 5, 6, 7, 8, 9, 10: send_rand(knnwpf_pkg::ACT_LOAD);
				default: send_rand(knnwpf_pkg::ACT_QUERY);
			endcase
		end
	endtask

	int ks [6] = '{1, 16, 2, 0, 31, 7};

	initial begin
		send_idle = 0; recv_stall = 0;
		req.valid = 0; req.action = knnwpf_pkg::ACT_LOAD; req.pos_x = 0; req.pos_y = 0;
		req.in_red = 0; req.in_green = 0; req.in_blue = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty store, extremes, ties, coincident sample
		send(knnwpf_pkg::ACT_QUERY, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_LOAD, 10'd0, 10'd0, 8'd255, 8'd0, 8'd255);
		send(knnwpf_pkg::ACT_QUERY, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_LOAD, 10'd1023, 10'd1023, 8'd0, 8'd255, 8'd0);
		send(knnwpf_pkg::ACT_LOAD, 10'd1023, 10'd0, 8'd10, 8'd20, 8'd30);
		send(knnwpf_pkg::ACT_LOAD, 10'd0, 10'd1023, 8'd10, 8'd20, 8'd29);
		send(knnwpf_pkg::ACT_LOAD, 10'd1023, 10'd0, 8'd10, 8'd20, 8'd30);
		send(knnwpf_pkg::ACT_QUERY, 10'd511, 10'd511, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_QUERY, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
		send(ACT_NONE, 10'd5, 10'd5, 8'd5, 8'd5, 8'd5);
		send(knnwpf_pkg::ACT_QUERY, 10'd512, 10'd0, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_CLEAR, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_QUERY, 10'd3, 10'd3, 8'd0, 8'd0, 8'd0);
		send(knnwpf_pkg::ACT_LOAD, 10'd3, 10'd3, 8'd1, 8'd2, 8'd3);
		send(knnwpf_pkg::ACT_QUERY, 10'd3, 10'd3, 8'd0, 8'd0, 8'd0);
		// random phases over register settings and idling profiles
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(knnwpf_pkg::CFG_K_NEIGHBORS, knnwpf_pkg::CFG_DATA_W'(ks[ph]));
			write_reg(knnwpf_pkg::CFG_WEIGHT_POWER, knnwpf_pkg::CFG_DATA_W'(ph % 4));
			case (ph)
				1: send_idle = 84;
				2: begin send_idle = 0; recv_stall = 84; end
				3: begin send_idle = 35; recv_stall = 35; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			phase(21);
		end
		req.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== knn_weighted_pixel_fill.f =====
+incdir+rtl/core
rtl/core/knnwpf_pkg.sv
rtl/core/knnwpf_if.sv
rtl/core/knnwpf_ram.sv
rtl/core/knnwpf_ctrl.sv
rtl/core/knnwpf_dp.sv
rtl/core/knn_weighted_pixel_fill.sv
rtl/core/knnwpf_chk.sv
dv/knn_weighted_pixel_fill_checker.sv
dv/knn_weighted_pixel_fill_tb.sv
